@@ hw/rtl/tssd_pkg.sv @@
// Package for the temperature seven-segment driver: codes, reset values,
// fixed-point conversion constants and the segment decoder.
// No dependencies.
package tssd_pkg;

   localparam int RAW_W   = 10;
   localparam int TEMP_W  = 10;
   localparam int NUM_W   = 23;
   localparam int CSR_IDX_W = 2;

   // Item kinds
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MIN  = 2'd2;

   localparam logic [RAW_W-1:0] RED_MIN_RST   = 10'd68;
   localparam logic [RAW_W-1:0] GREEN_MIN_RST = 10'd52;
   localparam logic [RAW_W-1:0] BLUE_MIN_RST  = 10'd37;

   // temp = round(raw * 10000 / 2046) = floor((raw * 5000 + 511) / 1023)
   localparam int NUM_SCALE = 5000;
   localparam int NUM_BIAS  = 511;
   localparam int DIV_BY    = 1023;
   // Raw readings at or above this value convert past the display limit
   localparam logic [RAW_W-1:0]  SAT_RAW  = 10'd205;
   localparam logic [TEMP_W-1:0] TEMP_MAX = 10'd999;

   // Indicator colors
   localparam logic [2:0] LED_OFF   = 3'b000;
   localparam logic [2:0] LED_BLUE  = 3'b001;
   localparam logic [2:0] LED_GREEN = 3'b010;
   localparam logic [2:0] LED_RED   = 3'b100;

   // Digit enables
   localparam logic [2:0] EN_NONE     = 3'b000;
   localparam logic [2:0] EN_HUNDREDS = 3'b001;
   localparam logic [2:0] EN_TENS     = 3'b010;
   localparam logic [2:0] EN_ONES     = 3'b100;

   localparam logic [7:0] SEG_DP    = 8'h80;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   typedef enum logic [1:0] {
      POS_HUNDREDS = 2'd0,
      POS_TENS     = 2'd1,
      POS_ONES     = 2'd2
   } pos_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7D;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h6F;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/tssd_req_if.sv @@
// Input channel of the temperature seven-segment driver: valid/ready plus
// the item kind and raw converter reading. Depends on tssd_pkg.
interface tssd_req_if import tssd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [RAW_W-1:0]  sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

@@ hw/rtl/tssd_rsp_if.sv @@
// Result channel of the temperature seven-segment driver: valid/ready plus
// digit enables, segment byte and indicator color. No dependencies.
interface tssd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  digit_enables;
   logic [7:0]  segment_code;
   logic [2:0]  led_color;

   modport source (output valid, output digit_enables, output segment_code,
                   output led_color, input ready);
   modport sink   (input valid, input digit_enables, input segment_code,
                   input led_color, output ready);
endinterface

@@ hw/rtl/temperature_seven_segment_driver_unit.sv @@
// Items pass the input register, then the result register. Throughput: one
// transaction per cycle unless the result channel stalls; the stage between
// input and result registers (divide-by-1023 correction, digit extraction)
// holds one item at a time and advances whenever the result register is free.
// Reset (synchronous, active high): thresholds 68/52/37, temperature, scan
// position, indicator and held digit outputs cleared, both stages empty.
module temperature_seven_segment_driver_unit import tssd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tssd_req_if.sink              req_if,
   tssd_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [RAW_W-1:0]      csr_wdata
);

   // Threshold registers
   logic [RAW_W-1:0]  red_min_ff, green_min_ff, blue_min_ff;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_action_ff;
   logic [RAW_W-1:0]  s1_sample_ff;
   logic [NUM_W-1:0]  s1_num_ff, s1_num_in;
   logic              s1_sat_ff, s1_sat_in;

   // Block state
   logic [TEMP_W-1:0] temp_ff, temp_in;
   pos_type           pos_ff, pos_in;
   logic [2:0]        led_ff, led_in;
   logic [2:0]        held_en_ff, held_en_in;
   logic [7:0]        held_seg_ff, held_seg_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_en_ff, rsp_en_in;
   logic [7:0]        rsp_seg_ff, rsp_seg_in;
   logic [2:0]        rsp_led_ff, rsp_led_in;

   logic              out_ready;
   logic              req_fire;
   logic              s1_fire;

   // Conversion datapath
   logic [NUM_W:0]    quot_sum;
   logic [13:0]       quot_est;
   logic [NUM_W:0]    quot_prod;
   logic [NUM_W:0]    quot_rem;
   logic [13:0]       quot;
   logic [TEMP_W-1:0] temp_new;
   logic [2:0]        color_new;

   // Digit extraction
   logic [15:0]       hund_prod;
   logic [3:0]        hund_digit;
   logic [TEMP_W-1:0] rem_full;
   logic [6:0]        rem_low;
   logic [14:0]       tens_prod;
   logic [3:0]        tens_digit;
   logic [6:0]        ones_full;
   logic [3:0]        ones_digit;
   logic [2:0]        tick_en;
   logic [7:0]        tick_seg;

   assign out_ready     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || out_ready;
   assign req_fire      = req_if.valid && req_if.ready;
   assign s1_fire       = s1_valid_ff && out_ready;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.digit_enables = rsp_en_ff;
   assign rsp_if.segment_code  = rsp_seg_ff;
   assign rsp_if.led_color     = rsp_led_ff;

   // Numerator and saturation flag are formed ahead of the input register
   always_comb begin
      s1_valid_in = req_if.ready ? req_if.valid : s1_valid_ff;
      s1_num_in   = NUM_W'(req_if.sample) * NUM_W'(NUM_SCALE) + NUM_W'(NUM_BIAS);
      s1_sat_in   = (req_if.sample >= SAT_RAW);
   end

   // Divide by 1023: estimate via x/1024 * (1 + 1/1024), then correct by one
   always_comb begin
      quot_sum  = {1'b0, s1_num_ff} + {11'b0, s1_num_ff[NUM_W-1:10]};
      quot_est  = quot_sum[NUM_W:10];
      quot_prod = {quot_est, 10'b0} - {10'b0, quot_est};
      quot_rem  = {1'b0, s1_num_ff} - quot_prod;
      quot      = (quot_rem >= (NUM_W+1)'(DIV_BY)) ? quot_est + 14'd1 : quot_est;
      temp_new  = s1_sat_ff ? TEMP_MAX : quot[TEMP_W-1:0];

      if (s1_sample_ff >= red_min_ff) begin
         color_new = LED_RED;
      end else if (s1_sample_ff >= green_min_ff) begin
         color_new = LED_GREEN;
      end else if (s1_sample_ff >= blue_min_ff) begin
         color_new = LED_BLUE;
      end else begin
         color_new = LED_OFF;
      end
   end

   // Decimal digits of a value below 1000 by reciprocal multiplies
   always_comb begin
      hund_prod  = 16'(temp_ff) * 16'd41;
      hund_digit = hund_prod[15:12];
      rem_full   = temp_ff - TEMP_W'(hund_digit) * TEMP_W'(100);
      rem_low    = rem_full[6:0];
      tens_prod  = 15'(rem_low) * 15'd205;
      tens_digit = tens_prod[14:11];
      ones_full  = rem_low - 7'(tens_digit) * 7'd10;
      ones_digit = ones_full[3:0];
   end

   // Scan outputs for the current position
   always_comb begin
      case (pos_ff)
         POS_HUNDREDS: begin
            tick_seg = seg_code(hund_digit);
            tick_en  = (temp_ff >= TEMP_W'(100)) ? EN_HUNDREDS : EN_NONE;
         end
         POS_TENS: begin
            tick_seg = seg_code(tens_digit) | SEG_DP;
            tick_en  = EN_TENS;
         end
         POS_ONES: begin
            tick_seg = seg_code(ones_digit);
            tick_en  = EN_ONES;
         end
         default: begin
            tick_seg = SEG_BLANK;
            tick_en  = EN_NONE;
         end
      endcase
   end

   // Scan position advance
   always_comb begin
      case (pos_ff)
         POS_HUNDREDS: pos_in = POS_TENS;
         POS_TENS:     pos_in = POS_ONES;
         default:      pos_in = POS_HUNDREDS;
      endcase
      if (!(s1_fire && s1_action_ff == ACT_TICK)) begin
         pos_in = pos_ff;
      end
   end

   // State and result next values
   always_comb begin
      temp_in     = temp_ff;
      led_in      = led_ff;
      held_en_in  = held_en_ff;
      held_seg_in = held_seg_ff;
      if (s1_fire) begin
         if (s1_action_ff == ACT_SAMPLE) begin
            temp_in = temp_new;
            led_in  = color_new;
         end else begin
            held_en_in  = tick_en;
            held_seg_in = tick_seg;
         end
      end

      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
      if (s1_fire) begin
         rsp_en_in  = (s1_action_ff == ACT_TICK) ? tick_en : held_en_ff;
         rsp_seg_in = (s1_action_ff == ACT_TICK) ? tick_seg : held_seg_ff;
         rsp_led_in = (s1_action_ff == ACT_SAMPLE) ? color_new : led_ff;
      end else begin
         rsp_en_in  = rsp_en_ff;
         rsp_seg_in = rsp_seg_ff;
         rsp_led_in = rsp_led_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_min_ff   <= RED_MIN_RST;
         green_min_ff <= GREEN_MIN_RST;
         blue_min_ff  <= BLUE_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RED_MIN:   red_min_ff   <= csr_wdata;
            CSR_GREEN_MIN: green_min_ff <= csr_wdata;
            CSR_BLUE_MIN:  blue_min_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         temp_ff      <= '0;
         pos_ff       <= POS_HUNDREDS;
         led_ff       <= LED_OFF;
         held_en_ff   <= EN_NONE;
         held_seg_ff  <= SEG_BLANK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         temp_ff      <= temp_in;
         pos_ff       <= pos_in;
         led_ff       <= led_in;
         held_en_ff   <= held_en_in;
         held_seg_ff  <= held_seg_in;
      end
   end

   // Payload registers: load the input stage on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_if.action;
         s1_sample_ff <= req_if.sample;
         s1_num_ff    <= s1_num_in;
         s1_sat_ff    <= s1_sat_in;
      end
      rsp_en_ff  <= rsp_en_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_led_ff <= rsp_led_in;
   end

endmodule

@@ hw/rtl/tssd_checker.sv @@
// Port-level checks for the temperature seven-segment driver, bound to the
// top level. Depends on temperature_seven_segment_driver_unit.
module tssd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  digit_enables,
   input logic [7:0]  segment_code,
   input logic [2:0]  led_color
);

   // A stalled transaction stays on the port unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(segment_code)
         && $stable(digit_enables) && $stable(led_color))
      else $error("result changed while stalled");

   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(led_color))
      else $error("more than one indicator color lit");

   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(digit_enables))
      else $error("more than one digit driven");

   // Decimal point lights exactly when the tens digit is driven
   a_dp_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (segment_code[7] == digit_enables[1]))
      else $error("decimal point does not follow tens position");

endmodule

bind temperature_seven_segment_driver_unit tssd_checker u_tssd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .digit_enables (rsp_if.digit_enables),
   .segment_code  (rsp_if.segment_code),
   .led_color     (rsp_if.led_color)
);

@@ tb/sv/temperature_seven_segment_driver_unit_tb.sv @@
// Self-checking bench for the temperature seven-segment driver: converter
// samples and refresh ticks in, one display transaction out per item.
// Depends on tssd_pkg, tssd_req_if, tssd_rsp_if and the driver RTL.
module temperature_seven_segment_driver_unit_tb import tssd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // Seven-segment glyphs for digits 0..9, digit d at bits [8*d +: 8]
   localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                     8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 190;
   localparam int LIMIT_NS      = 2_000_000;

   typedef struct packed {
      logic             action;
      logic [RAW_W-1:0] sample;
   } reading_type;

   typedef struct packed {
      logic [2:0] digit_enables;
      logic [7:0] segment_code;
      logic [2:0] led_color;
   } display_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RAW_W-1:0]     csr_wdata;

   tssd_req_if req_if ();
   tssd_rsp_if rsp_if ();

   temperature_seven_segment_driver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block's thresholds and display state
   logic [RAW_W-1:0]  m_red, m_green, m_blue;
   logic [TEMP_W-1:0] m_temp;
   pos_type           m_pos;
   logic [2:0]        m_led, m_en;
   logic [7:0]        m_seg;

   reading_type pending_readings[$];
   display_type due_displays[$];
   display_type want;
   logic        req_taken;
   int          send_idle_pct, recv_stall_pct;
   int          mismatches, n_samples, n_ticks;

   function automatic display_type advance_display(input logic act,
                                                   input logic [RAW_W-1:0] raw);
      int unsigned t;
      int unsigned d;
      display_type r;
      if (act == ACT_SAMPLE) begin
         // round to nearest tenth of a degree; no exact halves exist
         t = (32'(raw) * 10000 + 1023) / 2046;
         m_temp = (t > TEMP_MAX) ? TEMP_MAX : t[TEMP_W-1:0];
         if (raw >= m_red) m_led = LED_RED;
         else if (raw >= m_green) m_led = LED_GREEN;
         else if (raw >= m_blue) m_led = LED_BLUE;
         else m_led = LED_OFF;
      end else begin
         case (m_pos)
            POS_HUNDREDS: begin
               d = (m_temp / 100) % 10;
               m_seg = GLYPHS[d*8 +: 8];
               m_en = (m_temp >= 100) ? EN_HUNDREDS : EN_NONE;
            end
            POS_TENS: begin
               d = (m_temp / 10) % 10;
               m_seg = GLYPHS[d*8 +: 8] | SEG_DP;
               m_en = EN_TENS;
            end
            POS_ONES: begin
               d = m_temp % 10;
               m_seg = GLYPHS[d*8 +: 8];
               m_en = EN_ONES;
            end
            default: begin
               m_seg = SEG_BLANK;
               m_en = EN_NONE;
            end
         endcase
         m_pos = (m_pos == POS_ONES) ? POS_HUNDREDS : pos_type'(m_pos + 2'd1);
      end
      r.digit_enables = m_en;
      r.segment_code  = m_seg;
      r.led_color     = m_led;
      return r;
   endfunction

   task automatic log_mismatch(input string field, input int got, input int exp);
      $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h",
               field, $time, got, exp);
      mismatches++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [RAW_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RED_MIN:   m_red = val;
         CSR_GREEN_MIN: m_green = val;
         CSR_BLUE_MIN:  m_blue = val;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input logic [RAW_W-1:0] red,
                                 input logic [RAW_W-1:0] green,
                                 input logic [RAW_W-1:0] blue);
      csr_write(CSR_RED_MIN, red);
      csr_write(CSR_GREEN_MIN, green);
      csr_write(CSR_BLUE_MIN, blue);
   endtask

   task automatic queue_reading(input logic act, input logic [RAW_W-1:0] raw);
      reading_type it;
      it.action = act;
      it.sample = raw;
      pending_readings.push_back(it);
   endtask

   // Hold off until every transaction has been sent and answered
   task automatic wait_quiet();
      while (pending_readings.size() != 0 || req_if.valid || due_displays.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Driver: hold a transaction until it is taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_if.valid  <= 1'b1;
            req_if.action <= pending_readings[0].action;
            req_if.sample <= pending_readings[0].sample;
            pending_readings.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor: check results first, then predict newly taken transactions
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_displays.size() == 0) begin
            log_mismatch("unexpected result", rsp_if.segment_code, 0);
         end else begin
            want = due_displays.pop_front();
            if (rsp_if.digit_enables !== want.digit_enables)
               log_mismatch("digit_enables", rsp_if.digit_enables, want.digit_enables);
            if (rsp_if.segment_code !== want.segment_code)
               log_mismatch("segment_code", rsp_if.segment_code, want.segment_code);
            if (rsp_if.led_color !== want.led_color)
               log_mismatch("led_color", rsp_if.led_color, want.led_color);
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         due_displays.push_back(advance_display(req_if.action, req_if.sample));
         if (req_if.action == ACT_TICK) n_ticks++;
         else n_samples++;
      end
   end

   initial begin
      int p, i, near;
      logic [RAW_W-1:0] raw;
      req_if.valid  = 1'b0;
      req_if.action = ACT_SAMPLE;
      req_if.sample = '0;
      rsp_if.ready  = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_RED_MIN;
      csr_wdata = '0;
      req_taken = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      n_samples  = 0;
      n_ticks    = 0;
      m_red   = RED_MIN_RST;
      m_green = GREEN_MIN_RST;
      m_blue  = BLUE_MIN_RST;
      m_temp  = '0;
      m_pos   = POS_HUNDREDS;
      m_led   = LED_OFF;
      m_en    = EN_NONE;
      m_seg   = SEG_BLANK;
      reset   = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unmapped register index must be dropped
      csr_write(CSR_SPARE, '1);

      // scan a zero reading before any sample; tick ignores its sample field
      for (i = 0; i < 3; i++) queue_reading(ACT_TICK, '1);
      // indicator edges around the reset thresholds
      queue_reading(ACT_SAMPLE, 10'd36);
      queue_reading(ACT_SAMPLE, 10'd37);
      queue_reading(ACT_SAMPLE, 10'd51);
      queue_reading(ACT_SAMPLE, 10'd52);
      queue_reading(ACT_SAMPLE, 10'd67);
      queue_reading(ACT_SAMPLE, 10'd68);
      for (i = 0; i < 3; i++) queue_reading(ACT_TICK, '0);
      // below ten degrees: hundreds blanked
      queue_reading(ACT_SAMPLE, 10'd10);
      for (i = 0; i < 3; i++) queue_reading(ACT_TICK, 10'h2AA);
      // last value under the display limit, then saturation
      queue_reading(ACT_SAMPLE, 10'd204);
      queue_reading(ACT_SAMPLE, SAT_RAW);
      queue_reading(ACT_SAMPLE, 10'd1023);
      queue_reading(ACT_SAMPLE, 10'd0);
      for (i = 0; i < 3; i++) queue_reading(ACT_TICK, 10'h155);
      queue_reading(ACT_SAMPLE, 10'd512);
      queue_reading(ACT_TICK, '0);
      wait_quiet();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_thresholds(RED_MIN_RST, GREEN_MIN_RST, BLUE_MIN_RST);
            1: set_thresholds(10'd0, 10'd0, 10'd0);
            2: set_thresholds(10'd1023, 10'd1023, 10'd1023);
            3: set_thresholds(10'd100, 10'd500, 10'd900);
            4: set_thresholds(10'd1023, 10'd0, 10'd512);
            default: begin
               csr_write(CSR_SPARE, RAW_W'($urandom_range(0, 1023)));
               set_thresholds(RAW_W'($urandom_range(0, 1023)),
                              RAW_W'($urandom_range(0, 1023)),
                              RAW_W'($urandom_range(0, 1023)));
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 3))
               0: raw = RAW_W'($urandom_range(0, 1023));
               3: begin
                  case ($urandom_range(0, 2))
                     0: near = m_red;
                     1: near = m_green;
                     default: near = m_blue;
                  endcase
                  near = near + int'($urandom_range(0, 4)) - 2;
                  if (near < 0) near = 0;
                  if (near > 1023) near = 1023;
                  raw = near[RAW_W-1:0];
               end
               default: raw = RAW_W'($urandom_range(0, 230));
            endcase
            queue_reading(1'($urandom_range(0, 1)), raw);
         end
         // sender pauses here until the whole phase has been answered
         wait_quiet();
      end

      $display("covered %0d samples and %0d refresh ticks under %0d threshold settings",
               n_samples, n_ticks, RANDOM_PHASES + 1);
      $display("idle and stall mixes on both channels, %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("temperature_seven_segment_driver_unit_tb OK");
      end else begin
         $display("temperature_seven_segment_driver_unit_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #LIMIT_NS;
      $display("timeout with %0d results outstanding", due_displays.size());
      $display("temperature_seven_segment_driver_unit_tb NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/tssd_pkg.sv
hw/rtl/tssd_req_if.sv
hw/rtl/tssd_rsp_if.sv
hw/rtl/temperature_seven_segment_driver_unit.sv
hw/rtl/tssd_checker.sv
tb/sv/temperature_seven_segment_driver_unit_tb.sv
